// File: rtl/core/utf8h_pkg.sv
// Package for the UTF-8 character histogram.
// Holds lead byte limits, parameter defaults and the structs passed between modules.
// No dependencies.
`default_nettype none

package utf8h_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;

    typedef struct packed {
        logic active;
        logic done;
        logic is_new;
    } hop_ctrl_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic [2:0]  len;
    } launch_t;

endpackage

`default_nettype wire

// File: rtl/core/utf8h_assembler.sv
// Byte grouping for the UTF-8 character histogram.
// Collects bytes into characters and launches one table search per character.
// Depends on utf8h_pkg.
`default_nettype none

module utf8h_assembler
    import utf8h_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    output logic            in_stall,
    input  wire logic       release_busy,
    output launch_t         launch
);

    logic        busy_reg, busy_next;
    logic        launch_reg, launch_next;
    logic [2:0]  open_reg, open_next;
    logic [1:0]  taken_reg, taken_next;
    logic [23:0] partial_reg, partial_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  len_reg, len_next;
    logic        accept;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        launch_next  = 1'b0;
        open_next    = open_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;
        word_next    = word_reg;
        len_next     = len_reg;
        if (release_busy)
        begin
            busy_next = 1'b0;
        end
        if (accept)
        begin
            if (open_reg == 3'd0)
            begin
                if (in_byte <= ASCII_MAX)
                begin
                    busy_next   = 1'b1;
                    launch_next = 1'b1;
                    word_next   = {in_byte, 24'h000000};
                    len_next    = 3'd1;
                end
                else if (in_byte inside {[LEAD2_LO:LEAD2_HI]})
                begin
                    open_next    = 3'd2;
                    taken_next   = 2'd1;
                    partial_next = {16'h0000, in_byte};
                end
                else if (in_byte inside {[LEAD3_LO:LEAD3_HI]})
                begin
                    open_next    = 3'd3;
                    taken_next   = 2'd1;
                    partial_next = {16'h0000, in_byte};
                end
                else if (in_byte inside {[LEAD4_LO:LEAD4_HI]})
                begin
                    open_next    = 3'd4;
                    taken_next   = 2'd1;
                    partial_next = {16'h0000, in_byte};
                end
            end
            else if (({1'b0, taken_reg} + 3'd1) < open_reg)
            begin
                partial_next = {partial_reg[15:0], in_byte};
                taken_next   = taken_reg + 2'd1;
            end
            else
            begin
                busy_next    = 1'b1;
                launch_next  = 1'b1;
                len_next     = open_reg;
                open_next    = 3'd0;
                taken_next   = 2'd0;
                partial_next = 24'h000000;
                case (open_reg)
                    3'd2:    word_next = {partial_reg[7:0], in_byte, 16'h0000};
                    3'd3:    word_next = {partial_reg[15:0], in_byte, 8'h00};
                    default: word_next = {partial_reg, in_byte};
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            launch_reg  <= 1'b0;
            open_reg    <= 3'd0;
            taken_reg   <= 2'd0;
            partial_reg <= 24'h000000;
        end
        else
        begin
            busy_reg    <= busy_next;
            launch_reg  <= launch_next;
            open_reg    <= open_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        len_reg  <= len_next;
    end

    assign launch = '{valid: launch_reg, word: word_reg, len: len_reg};

endmodule

`default_nettype wire

// File: rtl/core/utf8h_slot_cell.sv
// One slot of the character table, a link in the search chain.
// Compares the passing search with its character, counts or claims, and hands on.
// Depends on utf8h_pkg.
`default_nettype none

module utf8h_slot_cell
    import utf8h_pkg::*;
#(
    parameter int IDX_W       = 8,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int SLOT_INDEX  = 0
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [31:0]            word,
    input  wire hop_ctrl_t              hop_in,
    input  wire logic [IDX_W-1:0]       idx_in,
    input  wire logic [COUNT_WIDTH-1:0] cnt_in,
    output hop_ctrl_t                   hop_out,
    output logic [IDX_W-1:0]            idx_out,
    output logic [COUNT_WIDTH-1:0]      cnt_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_INDEX);

    logic                   valid_reg, valid_next;
    logic [31:0]            char_reg, char_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    hop_ctrl_t              hop_reg, hop_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   searching;
    logic                   match;
    logic                   claim;
    logic [COUNT_WIDTH-1:0] count_inc;

    always_comb
    begin
        searching  = hop_in.active && !hop_in.done;
        match      = searching && valid_reg && (char_reg == word);
        claim      = searching && !valid_reg;
        count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        hop_next   = hop_in;
        idx_next   = idx_in;
        cnt_next   = cnt_in;
        valid_next = valid_reg;
        char_next  = char_reg;
        count_next = count_reg;
        if (match)
        begin
            hop_next.done   = 1'b1;
            hop_next.is_new = 1'b0;
            idx_next        = MY_IDX;
            cnt_next        = count_inc;
            count_next      = count_inc;
        end
        else if (claim)
        begin
            hop_next.done   = 1'b1;
            hop_next.is_new = 1'b1;
            idx_next        = MY_IDX;
            cnt_next        = COUNT_WIDTH'(1);
            valid_next      = 1'b1;
            char_next       = word;
            count_next      = COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hop_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hop_reg   <= hop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        count_reg <= count_next;
        idx_reg   <= idx_next;
        cnt_reg   <= cnt_next;
    end

    assign hop_out = hop_reg;
    assign idx_out = idx_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/core/utf8_character_histogram_top.sv
// Top level of the UTF-8 character histogram.
// Instantiates utf8h_assembler and a chain of utf8h_slot_cell; depends on utf8h_pkg.
// Each lead, continuation or stray byte that does not complete a character is taken
// without a stall. A byte that completes a character launches a search that walks the
// slot chain one cell per cycle, so the input holds stall after such a byte until the
// result word is taken. The length of the slot chain sets how long that stall lasts.
`default_nettype none

module utf8_character_histogram_top
    import utf8h_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      char_word,
    output logic [2:0]       char_length,
    output logic [7:0]       entry_index,
    output logic [31:0]      entry_count,
    output logic             new_entry,
    output logic             table_full,
    output logic [8:0]       distinct_total,
    output logic [31:0]      char_total
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DST_W = $clog2(TABLE_DEPTH + 1);

    launch_t                launch;
    logic                   release_busy;
    hop_ctrl_t              hop_w [0:TABLE_DEPTH];
    logic [IDX_W-1:0]       idx_w [0:TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_w [0:TABLE_DEPTH];
    hop_ctrl_t              tail;

    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            word_reg, word_next;
    logic [2:0]             len_reg, len_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   new_reg, new_next;
    logic                   full_reg, full_next;
    logic [DST_W-1:0]       distinct_reg, distinct_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;

    utf8h_assembler u_assembler (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_byte      (in_byte),
        .in_stall     (in_stall),
        .release_busy (release_busy),
        .launch       (launch)
    );

    assign hop_w[0] = '{active: launch.valid, done: 1'b0, is_new: 1'b0};
    assign idx_w[0] = '0;
    assign cnt_w[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_slot
        utf8h_slot_cell #(
            .IDX_W       (IDX_W),
            .COUNT_WIDTH (COUNT_WIDTH),
            .SLOT_INDEX  (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .word    (launch.word),
            .hop_in  (hop_w[g]),
            .idx_in  (idx_w[g]),
            .cnt_in  (cnt_w[g]),
            .hop_out (hop_w[g+1]),
            .idx_out (idx_w[g+1]),
            .cnt_out (cnt_w[g+1])
        );
    end

    assign tail         = hop_w[TABLE_DEPTH];
    assign release_busy = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        distinct_next  = distinct_reg;
        total_next     = total_reg;
        if (release_busy)
        begin
            out_valid_next = 1'b0;
        end
        if (tail.active)
        begin
            out_valid_next = 1'b1;
            word_next      = launch.word;
            len_next       = launch.len;
            idx_next       = tail.done ? idx_w[TABLE_DEPTH] : '0;
            cnt_next       = tail.done ? cnt_w[TABLE_DEPTH] : '0;
            new_next       = tail.done && tail.is_new;
            full_next      = !tail.done;
            if (tail.done && tail.is_new)
            begin
                distinct_next = distinct_reg + 1'b1;
            end
            if (tail.done && (total_reg != '1))
            begin
                total_next = total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            distinct_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            distinct_reg  <= distinct_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        new_reg  <= new_next;
        full_reg <= full_next;
    end

    assign out_valid      = out_valid_reg;
    assign char_word      = word_reg;
    assign char_length    = len_reg;
    assign entry_index    = 8'(idx_reg);
    assign entry_count    = 32'(cnt_reg);
    assign new_entry      = new_reg;
    assign table_full     = full_reg;
    assign distinct_total = 9'(distinct_reg);
    assign char_total     = 32'(total_reg);

endmodule

`default_nettype wire

// File: rtl/core/utf8h_checker.sv
// Port-level checks for the UTF-8 character histogram.
// Watches the ports of utf8_character_histogram_top and is bound to it below.
// Depends on nothing else.
`default_nettype none

module utf8h_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] char_word,
    input wire logic [2:0]  char_length,
    input wire logic [31:0] entry_count,
    input wire logic        new_entry,
    input wire logic        table_full,
    input wire logic [31:0] char_total
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_word))
        else $error("Result word changed while stalled.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(new_entry && table_full))
        else $error("Result word is both newly inserted and dropped.");

    a_new_count_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_entry |-> entry_count == 32'd1)
        else $error("Newly inserted character does not have a count of one.");

    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !table_full |-> entry_count != 32'd0 && char_total != 32'd0)
        else $error("Counted character shows a zero count.");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> char_length >= 3'd1 && char_length <= 3'd4)
        else $error("Character length is out of range.");

endmodule

bind utf8_character_histogram_top utf8h_checker u_utf8h_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_word   (char_word),
    .char_length (char_length),
    .entry_count (entry_count),
    .new_entry   (new_entry),
    .table_full  (table_full),
    .char_total  (char_total)
);

`default_nettype wire

// File: verif/utf8_character_histogram_checker.sv
// Checker for the UTF-8 character histogram: watches both channels, keeps its own
// byte assembler and slot table, and compares every result word with the oldest prediction.
// Depends on utf8h_pkg for the lead byte limits and the default table size.

module utf8_character_histogram_checker
    import utf8h_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] char_word,
    input  wire logic [2:0]  char_length,
    input  wire logic [7:0]  entry_index,
    input  wire logic [31:0] entry_count,
    input  wire logic        new_entry,
    input  wire logic        table_full,
    input  wire logic [8:0]  distinct_total,
    input  wire logic [31:0] char_total,
    output int               failures,
    output int               pending,
    output int               chars_checked,
    output int               drops
);

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH_DEF) - 64'd1);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  length;
        logic [7:0]  index;
        logic [31:0] count;
        logic        inserted;
        logic        full;
        logic [8:0]  distinct;
        logic [31:0] total;
    } char_tally_t;

    char_tally_t tally_q[$];
    char_tally_t oldest;

    logic [2:0]  open_len;
    logic [1:0]  taken;
    logic [23:0] partial;
    logic        slot_used [TABLE_DEPTH_DEF];
    logic [31:0] slot_word [TABLE_DEPTH_DEF];
    logic [31:0] slot_hits [TABLE_DEPTH_DEF];
    logic [8:0]  distinct_n;
    logic [31:0] char_n;
    int          i;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 32'd1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (failures < 40)
        begin
            $display("mismatch in %s: got %h, expected %h (result %0d)",
                     what, got, want, chars_checked);
        end
        failures++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report(what, got, want);
        end
    endtask

    task automatic count_char(input logic [31:0] word, input logic [2:0] length);
        char_tally_t r;
        int hit;
        hit = -1;
        for (int s = 0; s < TABLE_DEPTH_DEF; s++)
        begin
            if (slot_used[s] && slot_word[s] == word)
            begin
                hit = s;
                break;
            end
        end
        r = '0;
        r.word = word;
        r.length = length;
        if (hit >= 0)
        begin
            slot_hits[hit] = sat_inc(slot_hits[hit]);
            r.index = 8'(hit);
            r.count = slot_hits[hit];
            char_n = sat_inc(char_n);
        end
        else if (distinct_n < TABLE_DEPTH_DEF)
        begin
            slot_used[distinct_n] = 1'b1;
            slot_word[distinct_n] = word;
            slot_hits[distinct_n] = 32'd1;
            r.index = distinct_n[7:0];
            r.count = 32'd1;
            r.inserted = 1'b1;
            distinct_n = distinct_n + 9'd1;
            char_n = sat_inc(char_n);
        end
        else
        begin
            r.full = 1'b1;
        end
        r.distinct = distinct_n;
        r.total = char_n;
        tally_q.push_back(r);
    endtask

    task automatic take_byte(input logic [7:0] b);
        logic [31:0] word;
        logic [2:0]  length;
        if (open_len == 3'd0)
        begin
            if (b <= ASCII_MAX)
            begin
                count_char({b, 24'h0}, 3'd1);
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                open_len = 3'd2;
                taken = 2'd1;
                partial = {16'h0, b};
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                open_len = 3'd3;
                taken = 2'd1;
                partial = {16'h0, b};
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                open_len = 3'd4;
                taken = 2'd1;
                partial = {16'h0, b};
            end
        end
        else if (taken + 1 < open_len)
        begin
            partial = {partial[15:0], b};
            taken = taken + 2'd1;
        end
        else
        begin
            word = {partial, b} << (8 * (4 - open_len));
            length = open_len;
            open_len = 3'd0;
            taken = 2'd0;
            partial = 24'h0;
            count_char(word, length);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_len = 3'd0;
            taken = 2'd0;
            partial = 24'h0;
            for (i = 0; i < TABLE_DEPTH_DEF; i++)
            begin
                slot_used[i] = 1'b0;
            end
            distinct_n = 9'd0;
            char_n = 32'd0;
            tally_q.delete();
            failures = 0;
            pending = 0;
            chars_checked = 0;
            drops = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tally_q.size() == 0)
                begin
                    report("result with nothing expected", char_word, 32'h0);
                end
                else
                begin
                    oldest = tally_q.pop_front();
                    check_field("char_word", char_word, oldest.word);
                    check_field("char_length", 32'(char_length), 32'(oldest.length));
                    check_field("entry_index", 32'(entry_index), 32'(oldest.index));
                    check_field("entry_count", entry_count, oldest.count);
                    check_field("new_entry", 32'(new_entry), 32'(oldest.inserted));
                    check_field("table_full", 32'(table_full), 32'(oldest.full));
                    check_field("distinct_total", 32'(distinct_total),
                                32'(oldest.distinct));
                    check_field("char_total", char_total, oldest.total);
                    chars_checked++;
                    if (oldest.full)
                    begin
                        drops++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                take_byte(in_byte);
            end
            pending = tally_q.size();
        end
    end

endmodule

// File: verif/utf8_character_histogram_top_tb.sv
// Testbench top for the UTF-8 character histogram: drives the byte stream and the result
// stall, runs the idle watchdog and gives the verdict.
// Depends on utf8h_pkg, utf8_character_histogram_top and utf8_character_histogram_checker.

module utf8_character_histogram_top_tb;
    import utf8h_pkg::*;

    localparam int          STALL_SPAN  = TABLE_DEPTH_DEF + 1;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          RANDOM_BYTES = 1270;
    localparam logic [7:0]  CONT_LO = 8'h80;
    localparam logic [7:0]  CONT_HI = 8'hBF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] char_word;
    logic [2:0]  char_length;
    logic [7:0]  entry_index;
    logic [31:0] entry_count;
    logic        new_entry;
    logic        table_full;
    logic [8:0]  distinct_total;
    logic [31:0] char_total;

    int          failures;
    int          pending;
    int          chars_checked;
    int          drops;
    int          bytes_sent;
    int          idle_cycles;
    int          hold_left;
    int          hold_reqs;
    int          holds_started;
    bit          steady;
    logic [31:0] seen_words [$];
    logic [2:0]  seen_lens [$];

    utf8_character_histogram_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_word      (char_word),
        .char_length    (char_length),
        .entry_index    (entry_index),
        .entry_count    (entry_count),
        .new_entry      (new_entry),
        .table_full     (table_full),
        .distinct_total (distinct_total),
        .char_total     (char_total)
    );

    utf8_character_histogram_checker hist_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_word      (char_word),
        .char_length    (char_length),
        .entry_index    (entry_index),
        .entry_count    (entry_count),
        .new_entry      (new_entry),
        .table_full     (table_full),
        .distinct_total (distinct_total),
        .char_total     (char_total),
        .failures       (failures),
        .pending        (pending),
        .chars_checked  (chars_checked),
        .drops          (drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        holds_started = 0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != holds_started)
            begin
                holds_started = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (steady)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 12);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic [2:0] n);
        for (int k = 0; k < n; k++)
        begin
            send_byte(w[31 - 8 * k -: 8]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic void make_char(output logic [31:0] w, output logic [2:0] n);
        int sel;
        sel = $urandom_range(9);
        n = (sel < 2) ? 3'd1 : (sel < 5) ? 3'd2 : (sel < 8) ? 3'd3 : 3'd4;
        w = '0;
        case (n)
            3'd1: w[31:24] = 8'($urandom_range(ASCII_MAX));
            3'd2: w[31:24] = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
            3'd3: w[31:24] = 8'($urandom_range(LEAD3_HI, LEAD3_LO));
            default: w[31:24] = 8'($urandom_range(LEAD4_HI, LEAD4_LO));
        endcase
        for (int k = 1; k < n; k++)
        begin
            w[31 - 8 * k -: 8] = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                           : 8'($urandom_range(CONT_HI, CONT_LO));
        end
    endfunction

    initial
    begin
        logic [7:0]  opening [26];
        logic [31:0] w;
        logic [2:0]  n;
        int          pick;
        int          k;
        int          counted;
        bit          held;
        bit          drained;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        steady = 1'b0;
        hold_reqs = 0;
        bytes_sent = 0;
        counted = 0;
        held = 1'b0;
        drained = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero byte twice, strays, both ends of every lead range, and leads or
        // arbitrary bytes taken as continuations.
        opening = '{8'h00, 8'h7F, 8'h00, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                    8'hC0, 8'h80, 8'hDF, 8'hBF,
                    8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hFF, 8'h00,
                    8'hF0, 8'h90, 8'h80, 8'h80, 8'hF7, 8'hC3, 8'hE2, 8'hF5,
                    8'h41};
        foreach (opening[j])
        begin
            send_byte(opening[j]);
        end

        // The receiver holds off while more characters are offered, so the block backs up.
        hold_reqs++;
        send_word(32'h61000000, 3'd1);
        send_word(32'hE282AC00, 3'd3);
        send_word(32'h62000000, 3'd1);
        drain();

        while (counted < RANDOM_BYTES)
        begin
            steady = (counted >= 300 && counted < 520);
            if (!held && counted >= 650)
            begin
                hold_reqs++;
                held = 1'b1;
            end
            if (!drained && counted >= 950)
            begin
                drain();
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                send_byte(8'($urandom_range(255)));
            end
            else if (pick < 37 && seen_words.size() > 0)
            begin
                k = $urandom_range(seen_words.size() - 1);
                send_word(seen_words[k], seen_lens[k]);
                counted += seen_lens[k];
            end
            else
            begin
                make_char(w, n);
                seen_words.push_back(w);
                seen_lens.push_back(n);
                send_word(w, n);
                counted += n;
            end
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (STALL_SPAN + 16) @(negedge clk);

        $display("Drove %0d bytes; %0d characters checked, %0d of them dropped on a full table.",
                 bytes_sent, chars_checked, drops);
        if (failures == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/utf8h_pkg.sv
rtl/core/utf8h_assembler.sv
rtl/core/utf8h_slot_cell.sv
rtl/core/utf8_character_histogram_top.sv
rtl/core/utf8h_checker.sv
verif/utf8_character_histogram_checker.sv
verif/utf8_character_histogram_top_tb.sv
